>>> rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int unsigned KeyWidth    = 32;
   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned CountOutW   = 8;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned ReqDataW    = 64;
   localparam int unsigned RspDataW    = 80;

   // Operation selector carried on the request tuser bit.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [StatusWidth-1:0] STATUS_OK         = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_FULL_DROP  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY_SKIP = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef struct packed {
      logic                         valid;
      logic signed [KeyWidth-1:0]   prio;
      logic signed [ValueWidth-1:0] payload;
   } entry_type;

   typedef struct packed {
      op_type                       op;
      logic signed [KeyWidth-1:0]   prio;
      logic signed [ValueWidth-1:0] payload;
   } cmd_type;

endpackage

>>> rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// The result of an item is registered as the item is accepted and shown in the cycle after.
// Throughput: one item per cycle while results are taken; every cell updates in the same cycle from the broadcast key.
// The output register frees as its result is taken, so a stalled result stalls the input.
// Reset (synchronous, active high) empties the queue at once: valid bits and count clear.
module sorted_priority_queue_top #(
   parameter int unsigned CAPACITY = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // priority_req [31:0], payload [63:32]
   input  logic [0:0]   req_tuser,  // func [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata   // head_priority [31:0], head_payload [63:32],
                                    // is_empty [64], entry_count [72:65],
                                    // status [74:73], zero [79:75]
);

   localparam int unsigned CountWidth = $clog2(CAPACITY + 1);

   spq_pkg::cmd_type   cmd;
   spq_pkg::entry_type slot_q    [CAPACITY];
   spq_pkg::entry_type slot_next [CAPACITY];
   logic               slot_stays [CAPACITY];

   logic [CountWidth-1:0]            count_ff;
   logic [CountWidth-1:0]            count_in;
   logic [spq_pkg::StatusWidth-1:0]  status;
   logic                             accept;
   logic                             is_full;
   logic                             is_none;
   logic                             rsp_valid_ff;
   logic [spq_pkg::RspDataW-1:0]     rsp_data_ff;
   logic [spq_pkg::RspDataW-1:0]     rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CountWidth'(CAPACITY));
   assign is_none    = (count_ff == '0);

   always_comb begin
      cmd.prio    = req_tdata[31:0];
      cmd.payload = req_tdata[63:32];
      cmd.op      = spq_pkg::OP_HOLD;
      count_in    = count_ff;
      status      = spq_pkg::STATUS_OK;
      if (accept) begin
         if (req_tuser[0] == spq_pkg::FUNC_INSERT) begin
            if (is_full) begin
               status = spq_pkg::STATUS_FULL_DROP;
            end else begin
               cmd.op   = spq_pkg::OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_none) begin
               status = spq_pkg::STATUS_EMPTY_SKIP;
            end else begin
               cmd.op   = spq_pkg::OP_REMOVE;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::entry_type left_slot;
      spq_pkg::entry_type right_slot;
      logic               left_stays;

      if (i == 0) begin : g_first
         // The head slot has nothing ahead of it, so an insert that passes it lands there.
         assign left_slot  = '0;
         assign left_stays = 1'b1;
      end else begin : g_inner
         assign left_slot  = slot_q[i-1];
         assign left_stays = slot_stays[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_body
         assign right_slot = slot_q[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_stays (left_stays),
         .right_slot (right_slot),
         .slot_ff    (slot_q[i]),
         .slot_in    (slot_next[i]),
         .stays      (slot_stays[i])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      if (slot_next[0].valid) begin
         rsp_data_in[31:0]  = slot_next[0].prio;
         rsp_data_in[63:32] = slot_next[0].payload;
      end
      rsp_data_in[64]    = (count_in == '0);
      rsp_data_in[72:65] = spq_pkg::CountOutW'(count_in);
      rsp_data_in[74:73] = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/spq_cell.sv
// One slot of the sorted queue: compares with the broadcast key and shifts with its neighbours.
module spq_cell (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type left_slot,
   input  logic               left_stays,
   input  spq_pkg::entry_type right_slot,
   output spq_pkg::entry_type slot_ff,
   output spq_pkg::entry_type slot_in,
   output logic               stays
);

   // An entry of equal or higher priority keeps its place, so ties leave in arrival order.
   assign stays = slot_ff.valid && (slot_ff.prio >= cmd.prio);

   always_comb begin
      slot_in = slot_ff;
      unique case (cmd.op)
         spq_pkg::OP_HOLD: begin
            slot_in = slot_ff;
         end
         spq_pkg::OP_INSERT: begin
            priority if (stays) begin
               slot_in = slot_ff;
            end else if (left_stays) begin
               slot_in.valid   = 1'b1;
               slot_in.prio    = cmd.prio;
               slot_in.payload = cmd.payload;
            end else begin
               slot_in = left_slot;
            end
         end
         spq_pkg::OP_REMOVE: begin
            slot_in = right_slot;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.prio    <= slot_in.prio;
      slot_ff.payload <= slot_in.payload;
   end

endmodule

>>> verif/pq_scoreboard_pkg.sv
// Scoreboard for the sorted priority queue: keeps a copy of the queue and checks every result.
package pq_scoreboard_pkg;

   typedef struct packed {
      logic [spq_pkg::KeyWidth-1:0]    head_prio;
      logic [spq_pkg::ValueWidth-1:0]  head_payload;
      logic                            is_empty;
      logic [spq_pkg::CountOutW-1:0]   count;
      logic [spq_pkg::StatusWidth-1:0] status;
   } queue_result_type;

   class queue_checker_type;
      int unsigned capacity;
      logic signed [spq_pkg::KeyWidth-1:0]   held_prio[$];
      logic signed [spq_pkg::ValueWidth-1:0] held_payload[$];
      queue_result_type                      awaited[$];
      int unsigned items_noted;
      int unsigned results_seen;
      int unsigned failures;
      int unsigned full_drops;
      int unsigned empty_skips;
      int unsigned peak_fill;

      function new(int unsigned cap);
         capacity = cap;
      endfunction

      function int unsigned fill();
         return held_prio.size();
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Applies one accepted item to the held queue and records the result it must give.
      function void note_item(logic func, logic signed [spq_pkg::KeyWidth-1:0] prio,
                              logic signed [spq_pkg::ValueWidth-1:0] value);
         queue_result_type want;
         int unsigned      pos;
         want.status = spq_pkg::STATUS_OK;
         if (func == spq_pkg::FUNC_INSERT) begin
            if (held_prio.size() >= capacity) begin
               want.status = spq_pkg::STATUS_FULL_DROP;
               full_drops++;
            end else begin
               // A new entry goes behind every entry of equal or higher priority.
               pos = 0;
               while (pos < held_prio.size() && !(held_prio[pos] < prio))
                  pos++;
               held_prio.insert(pos, prio);
               held_payload.insert(pos, value);
            end
         end else begin
            if (held_prio.size() == 0) begin
               want.status = spq_pkg::STATUS_EMPTY_SKIP;
               empty_skips++;
            end else begin
               void'(held_prio.pop_front());
               void'(held_payload.pop_front());
            end
         end
         if (held_prio.size() == 0) begin
            want.head_prio    = '0;
            want.head_payload = '0;
            want.is_empty     = 1'b1;
         end else begin
            want.head_prio    = held_prio[0];
            want.head_payload = held_payload[0];
            want.is_empty     = 1'b0;
         end
         want.count = spq_pkg::CountOutW'(held_prio.size());
         if (held_prio.size() > peak_fill)
            peak_fill = held_prio.size();
         items_noted++;
         awaited.push_back(want);
      endfunction

      function void check_field(string what, logic [31:0] exp, logic [31:0] got);
         if (exp !== got) begin
            failures++;
            if (failures <= 10)
               $display("result %0d: %s expected %h, got %h", results_seen, what, exp, got);
         end
      endfunction

      function void check_result(logic [spq_pkg::RspDataW-1:0] data);
         queue_result_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result %0d arrived with no item awaiting it: %h", results_seen, data);
            return;
         end
         want = awaited.pop_front();
         check_field("head_priority", want.head_prio, data[31:0]);
         check_field("head_payload", want.head_payload, data[63:32]);
         check_field("is_empty", 32'(want.is_empty), 32'(data[64]));
         check_field("entry_count", 32'(want.count), 32'(data[72:65]));
         check_field("status", 32'(want.status), 32'(data[74:73]));
         check_field("padding", 32'd0, 32'(data[79:75]));
      endfunction

      function void close_out();
         if (awaited.size() != 0) begin
            failures++;
            $display("%0d results never arrived", awaited.size());
         end
      endfunction
   endclass

endpackage

>>> verif/sorted_priority_queue_top_tb.sv
// Testbench for the sorted priority queue top level: random stream traffic checked item by item.
module sorted_priority_queue_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Capacity    = 128;
   localparam int unsigned RandomItems = 1150;
   localparam int unsigned IdleLimit   = 2000;

   typedef enum logic [1:0] {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_kind_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [spq_pkg::ReqDataW-1:0] req_tdata  = '0;  // priority_req [31:0], payload [63:32]
   logic [0:0]                   req_tuser  = '0;  // func [0]
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [spq_pkg::RspDataW-1:0] rsp_tdata;        // head_priority, head_payload, is_empty,
                                                   // entry_count, status, zero padding

   pq_scoreboard_pkg::queue_checker_type queue_check;
   int unsigned  send_gap_pct = 0;
   int unsigned  stall_pct    = 0;
   int unsigned  stall_left   = 0;
   int unsigned  idle_cycles  = 0;
   int unsigned  random_sent  = 0;
   int unsigned  phases_run   = 0;

   sorted_priority_queue_top #(
      .CAPACITY(Capacity)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly no gap, some short ones and now and then a long one.
   function automatic int unsigned pick_gap(int unsigned pct);
      if ($urandom_range(99) >= pct)
         return 0;
      if ($urandom_range(9) < 8)
         return $urandom_range(3, 1);
      return $urandom_range(30, 4);
   endfunction

   // Small values give plenty of ties; the extremes and full-range values cover the rest.
   function automatic logic [spq_pkg::KeyWidth-1:0] pick_priority();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4)
         return spq_pkg::KeyWidth'($urandom_range(8) - 4);
      if (r < 6) begin
         case ($urandom_range(4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom();
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(logic func, logic [spq_pkg::KeyWidth-1:0] prio,
                            logic [spq_pkg::ValueWidth-1:0] value);
      int unsigned gap;
      gap = pick_gap(send_gap_pct);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {value, prio};
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic run_phase(phase_kind_type kind);
      int unsigned insert_pct;
      int unsigned extra;
      int unsigned len;
      int unsigned n;
      bit          quiet;
      bit          done;
      logic        func;
      quiet        = ($urandom_range(3) == 0);
      send_gap_pct = quiet ? 0 : $urandom_range(40, 5);
      stall_pct    = quiet ? 0 : $urandom_range(30, 3);
      extra        = $urandom_range(6, 2);
      len          = $urandom_range(100, 30);
      case (kind)
         PH_FILL:  insert_pct = 95;
         PH_DRAIN: insert_pct = 5;
         default:  insert_pct = $urandom_range(70, 30);
      endcase
      n    = 0;
      done = 1'b0;
      while (!done) begin
         func = ($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT : spq_pkg::FUNC_REMOVE;
         send_item(func, pick_priority(), $urandom());
         n++;
         random_sent++;
         // Fill and drain phases linger at the bound to hit the full and empty cases.
         case (kind)
            PH_FILL: begin
               if (queue_check.fill() == Capacity) begin
                  if (extra == 0)
                     done = 1'b1;
                  else
                     extra--;
               end
            end
            PH_DRAIN: begin
               if (queue_check.fill() == 0) begin
                  if (extra == 0)
                     done = 1'b1;
                  else
                     extra--;
               end
            end
            default: done = (n >= len);
         endcase
      end
      phases_run++;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            queue_check.note_item(req_tuser[0], req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready)
            queue_check.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: nothing moved for %0d cycles", idle_cycles);
            $display("sorted_priority_queue_top_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      queue_check = new(Capacity);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_gap_pct = 20;
      stall_pct    = 10;
      // Remove on an empty queue, the priority extremes, ties in arrival order, then drain.
      send_item(spq_pkg::FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_item(spq_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(spq_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
      send_item(spq_pkg::FUNC_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_item(spq_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(spq_pkg::FUNC_INSERT, 32'h0000_0005, 32'h0000_0001);
      send_item(spq_pkg::FUNC_INSERT, 32'h0000_0005, 32'h0000_0002);
      send_item(spq_pkg::FUNC_INSERT, 32'h0000_0005, 32'h0000_0003);
      send_item(spq_pkg::FUNC_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
      repeat (8) send_item(spq_pkg::FUNC_REMOVE, $urandom(), $urandom());
      send_item(spq_pkg::FUNC_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
      send_item(spq_pkg::FUNC_INSERT, 32'h8000_0000, 32'h0000_0001);
      send_item(spq_pkg::FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);

      run_phase(PH_FILL);
      run_phase(PH_DRAIN);
      while (random_sent < RandomItems) begin
         case ($urandom_range(3))
            0: run_phase(PH_FILL);
            1: run_phase(PH_DRAIN);
            default: run_phase(PH_MIXED);
         endcase
      end
      req_tvalid <= 1'b0;

      stall_pct = 0;
      while (queue_check.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      queue_check.close_out();

      $display("%0d items sent (%0d random over %0d phases), %0d results checked",
               queue_check.items_noted, random_sent, phases_run, queue_check.results_seen);
      $display("peak fill %0d of %0d, %0d inserts dropped when full, %0d removes on empty",
               queue_check.peak_fill, Capacity, queue_check.full_drops,
               queue_check.empty_skips);
      if (queue_check.failures == 0)
         $display("sorted_priority_queue_top_tb: done, clean");
      else
         $display("sorted_priority_queue_top_tb: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
verif/pq_scoreboard_pkg.sv
verif/sorted_priority_queue_top_tb.sv
